FILE: hdl/rld_pkg.sv
package rld_pkg;

  // Field widths
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int RATE_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Buffer accumulation
  localparam int MAX_FRAMES = 1024;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W      = 40;
  // A halved square is at most 2^28, so it needs 2*SAMPLE_W-3 bits.
  localparam int HSQ_W      = 2 * SAMPLE_W - 3;
  localparam int PAIR_W     = HSQ_W + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Division and square root
  localparam int DIV_W      = CNT_W + 1;
  localparam int DIV_STEPS  = SUM_W;
  localparam int MEAN_W     = HSQ_W;
  localparam int ROOT_W     = MEAN_W + 1;
  localparam int SQRT_STEPS = (MEAN_W + 1) / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Shared multiplier and accumulator
  localparam int MUL_A_W = RATE_W + 1;
  localparam int MUL_B_W = RATE_W;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 32;
  localparam int FRAC_W  = 16;
  localparam logic [MUL_A_W-1:0] COEF_OLD = MUL_A_W'(60948);
  localparam logic [MUL_A_W-1:0] COEF_NEW = MUL_A_W'(4588);
  localparam logic [MUL_A_W-1:0] UNITY    = MUL_A_W'(65536);
  localparam logic [ACC_W-1:0]   ROUND    = ACC_W'(32768);

  // Reset values of the registers and of the threshold
  localparam logic [RATE_W-1:0]  DECAY_RESET = RATE_W'(3277);
  localparam logic [LEVEL_W-1:0] MIN_RESET   = LEVEL_W'(3277);
  localparam logic [LEVEL_W-1:0] THR_RESET   = LEVEL_W'(3277);

  // Queue of closed buffers
  localparam int QDEPTH = 2;
  localparam int QCNT_W = $clog2(QDEPTH + 1);
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_RATE    = 2'd0,
    CFG_MIN_THRESHOLD = 2'd1
  } cfg_index_t;

  typedef struct packed {
    logic [RATE_W-1:0]  decay_rate;
    logic [LEVEL_W-1:0] min_threshold;
  } config_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } buffer_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              not_empty;
  } queue_status_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] smoothed;
    logic               onset;
    logic [LEVEL_W-1:0] threshold;
  } result_t;

endpackage

FILE: hdl/rld_front.sv
module rld_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [rld_pkg::SAMPLE_W-1:0] left_sample,
  input  logic signed [rld_pkg::SAMPLE_W-1:0] right_sample,
  input  logic                                last_frame,
  input  rld_pkg::queue_status_t              q_status,
  output logic                                push,
  output rld_pkg::buffer_t                    push_data
);
  import rld_pkg::*;

  logic                        accept;
  logic signed [2*SAMPLE_W-1:0] left_sq;
  logic signed [2*SAMPLE_W-1:0] right_sq;
  logic [PAIR_W-1:0]           pair;
  logic                        counted;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_inc;
  logic [QCNT_W:0]             busy;

  logic                        a_valid;
  logic                        a_last;
  logic [PAIR_W-1:0]           a_pair;
  logic [CNT_W-1:0]            a_count;

  logic [SUM_W-1:0]            sum;
  logic [SUM_W:0]              sum_add;
  logic [SUM_W-1:0]            sum_sat;

  // A closing frame in the adder stage reserves its queue slot before it is pushed.
  assign busy     = {1'b0, q_status.count} + {{QCNT_W{1'b0}}, a_valid & a_last};
  assign in_ready = busy < (QCNT_W + 1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  // Squares of both samples, halved twice (the square of the halved sample).
  assign left_sq  = left_sample * left_sample;
  assign right_sq = right_sample * right_sample;
  assign pair     = {1'b0, left_sq[HSQ_W+1:2]} + {1'b0, right_sq[HSQ_W+1:2]};

  // Frames beyond the limit add nothing but may still close the buffer.
  assign counted   = count < CNT_W'(MAX_FRAMES);
  assign count_inc = count + CNT_W'(counted);

  // First stage: squares and frame count.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_last  <= 1'b0;
      count   <= '0;
    end else begin
      a_valid <= accept;
      if (accept) begin
        a_last <= last_frame;
        count  <= last_frame ? '0 : count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pair  <= counted ? pair : '0;
      a_count <= count_inc;
    end
  end

  // Second stage: saturating accumulation of the buffer.
  assign sum_add = {1'b0, sum} + (SUM_W + 1)'(a_pair);
  assign sum_sat = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (a_valid) begin
      sum <= a_last ? '0 : sum_sat;
    end
  end

  // A closing frame hands the whole buffer to the queue.
  assign push            = a_valid && a_last;
  assign push_data.sum   = sum_sat;
  assign push_data.count = a_count;

endmodule

FILE: hdl/rld_queue.sv
module rld_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  rld_pkg::buffer_t       push_data,
  input  logic                   pop,
  output rld_pkg::buffer_t       head,
  output rld_pkg::queue_status_t status
);
  import rld_pkg::*;

  buffer_t           entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Storage of closed buffers.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head             = entries[rd_ptr];
  assign status.count     = count;
  assign status.not_empty = count != '0;

endmodule

FILE: hdl/rld_back.sv
module rld_back (
  input  logic             clk,
  input  logic             rst,
  input  rld_pkg::config_t cfg,
  input  logic             q_valid,
  input  rld_pkg::buffer_t head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output rld_pkg::result_t result
);
  import rld_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_DIV    = 8'b0000_0010,
    ST_SQRT   = 8'b0000_0100,
    ST_SM_OLD = 8'b0000_1000,
    ST_SM_NEW = 8'b0001_0000,
    ST_DC_OLD = 8'b0010_0000,
    ST_DC_MIN = 8'b0100_0000,
    ST_FINISH = 8'b1000_0000
  } state_t;

  state_t             state;
  logic [STEP_W-1:0]  step;

  logic [SUM_W-1:0]   dvd;
  logic [DIV_W-1:0]   rem;
  logic [DIV_W-1:0]   divisor;
  logic [DIV_W:0]     rem_sh;
  logic               ge;
  logic [DIV_W:0]     rem_sub;

  logic [ROOT_W-1:0]  sq_n;
  logic [ROOT_W-1:0]  sq_root;
  logic [ROOT_W-1:0]  sq_bit;
  logic [ROOT_W-1:0]  trial;
  logic [LEVEL_W-1:0] rms;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [ACC_W-1:0]   base;
  logic [PROD_W-1:0]  product;
  logic [PROD_W-1:0]  acc_sum;
  logic [ACC_W-1:0]   acc;
  logic [LEVEL_W-1:0] acc_level;

  logic [LEVEL_W-1:0] smoothed_state;
  logic [LEVEL_W-1:0] threshold_state;
  logic               out_free;
  logic               onset_next;

  assign pop      = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || out_ready;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh  = {rem, dvd[SUM_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = ge ? rem_sh - {1'b0, divisor} : rem_sh;

  // Digit-by-digit square root, one result bit per cycle.
  assign trial = sq_root + sq_bit;
  assign rms   = sq_root[LEVEL_W-1:0];

  // Shared multiplier: operands chosen by the step of the update.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    base  = acc;
    case (state)
      ST_SM_OLD: begin
        mul_a = COEF_OLD;
        mul_b = MUL_B_W'(smoothed_state);
        base  = ROUND;
      end
      ST_SM_NEW: begin
        mul_a = COEF_NEW;
        mul_b = MUL_B_W'(rms);
      end
      ST_DC_OLD: begin
        mul_a = UNITY - {1'b0, cfg.decay_rate};
        mul_b = MUL_B_W'(threshold_state);
        base  = ROUND;
      end
      ST_DC_MIN: begin
        mul_a = {1'b0, cfg.decay_rate};
        mul_b = MUL_B_W'(cfg.min_threshold);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product    = mul_a * mul_b;
  assign acc_sum    = PROD_W'(base) + product;
  assign acc_level  = acc[FRAC_W+LEVEL_W-1:FRAC_W];
  assign onset_next = rms > acc_level;

  // Sequencer and level state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      smoothed_state  <= '0;
      threshold_state <= THR_RESET;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (step == '0) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (step == '0) begin
            state <= ST_SM_OLD;
          end
        end
        ST_SM_OLD: begin
          state <= ST_SM_NEW;
        end
        ST_SM_NEW: begin
          state <= ST_DC_OLD;
        end
        ST_DC_OLD: begin
          smoothed_state <= acc_level;
          state          <= ST_DC_MIN;
        end
        ST_DC_MIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            threshold_state <= onset_next ? rms : acc_level;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers of the division, root and products.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        step <= STEP_W'(DIV_STEPS - 1);
        rem  <= '0;
        // An empty buffer divides zero by one, giving a level of zero.
        if (head.count == '0) begin
          dvd     <= '0;
          divisor <= DIV_W'(1);
        end else begin
          dvd     <= head.sum;
          divisor <= {head.count, 1'b0};
        end
      end
      ST_DIV: begin
        dvd  <= {dvd[SUM_W-2:0], ge};
        rem  <= rem_sub[DIV_W-1:0];
        step <= step - 1'b1;
        if (step == '0) begin
          step    <= STEP_W'(SQRT_STEPS - 1);
          sq_n    <= {1'b0, dvd[MEAN_W-2:0], ge};
          sq_root <= '0;
          sq_bit  <= ROOT_W'(1) << (2 * (SQRT_STEPS - 1));
        end
      end
      ST_SQRT: begin
        if (sq_n >= trial) begin
          sq_n    <= sq_n - trial;
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
        step   <= step - 1'b1;
      end
      ST_SM_OLD, ST_SM_NEW, ST_DC_OLD, ST_DC_MIN: begin
        acc <= acc_sum[ACC_W-1:0];
      end
      default: begin
      end
    endcase
    if (state == ST_FINISH && out_free) begin
      result.rms       <= rms;
      result.smoothed  <= smoothed_state;
      result.onset     <= onset_next;
      result.threshold <= onset_next ? rms : acc_level;
    end
  end

endmodule

FILE: hdl/rms_level_onset_detector.sv
// RMS level meter with a decaying onset threshold. Each input beat is one
// stereo frame; the beat marked last closes the buffer, and one result beat
// follows each closed buffer, holding the RMS of the halved samples, the
// smoothed level, the onset flag and the new threshold. In the back unit a
// closed buffer is taken from the queue, the divider forms the 40-bit mean
// one quotient bit at a time, the 15-bit root follows one bit at a time, four
// passes through one shared multiplier make the smoothing and threshold
// update, and a final step loads the result once the output is free. A queue
// of two closed buffers sits between the accumulator and this unit, so frames
// of the next buffer keep flowing; input stalls only while two buffers wait
// for the unit, and in the cycle after a closing frame is taken while one
// buffer already waits. Buffers of at least 61 frames stream without stalling
// while the output keeps up. Configuration writes are always accepted and
// should be made while the block is idle.
module rms_level_onset_detector (
  input  logic                                clk,
  input  logic                                rst,
  // Frame input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [2*rld_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // left_sample, right_sample
  input  logic                                s_axis_tlast,  // last_frame
  // Result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [47:0]                         m_axis_tdata,  // rms_level, smoothed_level,
                                                             // threshold, zero padding
  output logic                                m_axis_tuser,  // onset
  // Configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rld_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rld_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rld_pkg::*;

  config_t       cfg;
  logic          push;
  buffer_t       push_data;
  logic          pop;
  buffer_t       head;
  queue_status_t q_status;
  result_t       result;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.decay_rate    <= DECAY_RESET;
      cfg.min_threshold <= MIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DECAY_RATE) begin
        cfg.decay_rate <= cfg_data[RATE_W-1:0];
      end else if (cfg_index == CFG_MIN_THRESHOLD) begin
        cfg.min_threshold <= cfg_data[LEVEL_W-1:0];
      end
    end
  end

  rld_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .left_sample  (s_axis_tdata[SAMPLE_W-1:0]),
    .right_sample (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .last_frame   (s_axis_tlast),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  rld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  rld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_status.not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .result    (result)
  );

  // Output beat packing.
  assign m_axis_tdata = {3'b000, result.threshold, result.smoothed, result.rms};
  assign m_axis_tuser = result.onset;

  // A closing frame taken in always finds a free slot waiting for it.
  assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (q_status.count < QCNT_W'(QDEPTH)))
    else $error("closing frame accepted without a free queue slot");

  // The queue is never written while full unless it is read in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    push |-> (q_status.count < QCNT_W'(QDEPTH) || pop))
    else $error("buffer pushed into a full queue");

  // On an onset the threshold takes the RMS level.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (result.threshold == result.rms))
    else $error("onset result with threshold different from the level");

endmodule
